// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off during reset.
`define RAU_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off during reset.
`define RAU_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// What must hold in the cycle after a reset edge.
`define RAU_ASSERT_RST(lbl, cons, msg) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/rau_pkg.sv
// Types, codes and helpers for the rational arithmetic unit.
`default_nettype none
package rau_pkg;

   localparam int WORD_BITS = 32;
   localparam int OP_BITS   = 4;
   localparam int CNT_BITS  = $clog2(WORD_BITS);

   typedef logic [WORD_BITS-1:0] word_type;

   // operation codes
   localparam logic [OP_BITS-1:0] OP_ADD    = 4'd0;
   localparam logic [OP_BITS-1:0] OP_SUB    = 4'd1;
   localparam logic [OP_BITS-1:0] OP_MUL    = 4'd2;
   localparam logic [OP_BITS-1:0] OP_DIV    = 4'd3;
   localparam logic [OP_BITS-1:0] OP_POW    = 4'd4;
   localparam logic [OP_BITS-1:0] OP_NEG    = 4'd5;
   localparam logic [OP_BITS-1:0] OP_SCALAR = 4'd6;
   localparam logic [OP_BITS-1:0] OP_EQ     = 4'd7;
   localparam logic [OP_BITS-1:0] OP_NE     = 4'd8;
   localparam logic [OP_BITS-1:0] OP_GT     = 4'd9;
   localparam logic [OP_BITS-1:0] OP_GE     = 4'd10;
   localparam logic [OP_BITS-1:0] OP_LT     = 4'd11;
   localparam logic [OP_BITS-1:0] OP_LE     = 4'd12;

   typedef struct packed {
      logic [OP_BITS-1:0]          req_type;
      logic signed [WORD_BITS-1:0] a_num;
      logic signed [WORD_BITS-1:0] a_den;
      logic signed [WORD_BITS-1:0] b_num;
      logic signed [WORD_BITS-1:0] b_den;
      logic signed [WORD_BITS-1:0] int_operand;
   } req_item_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] res_num;
      logic signed [WORD_BITS-1:0] res_den;
      logic                        cmp_true;
      logic                        status;
   } rsp_item_type;

   typedef enum logic [4:0] {
      DP_NOP, DP_LOAD, DP_GCD_INIT, DP_DIV_GCD, DP_WB_GCD, DP_DIV_N, DP_WB_N,
      DP_DIV_D, DP_WB_D, DP_DIV_LCM, DP_DIV_SX, DP_DIV_SY, DP_ADD, DP_SUB,
      DP_NEG, DP_RD_AD, DP_POW_INIT, DP_E_SHIFT, DP_FIN_OK, DP_FIN_ERR
   } dp_op_type;

   // PAIR_D is the two denominators, for the lcm
   typedef enum logic [1:0] {PAIR_A, PAIR_B, PAIR_R, PAIR_D} pair_type;

   typedef enum logic [3:0] {
      M_AN_BN, M_AD_BD, M_AN_BD, M_AD_BN, M_AN_IOP, M_LCM, M_SX, M_SY,
      M_RN_X, M_RD_Y, M_X_X, M_Y_Y
   } mul_sel_type;

   typedef enum logic [2:0] {DST_RN, DST_RD, DST_L, DST_X, DST_Y} dst_type;

   typedef struct packed {
      dp_op_type   op;
      pair_type    pair;
      logic        mul_en;
      mul_sel_type msel;
      logic        wb_en;
      dst_type     dst;
   } dp_cmd_type;

   localparam dp_cmd_type CMD_NOP = '{op: DP_NOP, pair: PAIR_A, mul_en: 1'b0,
                                      msel: M_AN_BN, wb_en: 1'b0, dst: DST_RN};

   typedef struct packed {
      logic [OP_BITS-1:0] op;
      logic               ad_zero;
      logic               bd_zero;
      logic               ga_zero;
      logic               gb_zero;
      logic               div_done;
      logic               e_zero;
      logic               e_odd;
      logic               rd_zero;
   } dp_stat_type;

   typedef enum logic [4:0] {
      S_IDLE, S_CHECK, S_G_TEST, S_G_WAIT, S_R_CHK, S_R_WN, S_R_D, S_R_WD,
      S_L_DIV, S_L_WAIT, S_L_WB, S_X_DIV, S_X_WAIT, S_X_WB, S_Y_DIV, S_Y_WAIT,
      S_Y_WB, S_SCALED, S_M2, S_M3, S_SC, S_P_TEST, S_P1, S_P2, S_P3, S_P4,
      S_A_END, S_FIN, S_C_B, S_C_CMP
   } state_type;

   typedef enum logic {GR_LCM, GR_RED} gret_type;
   typedef enum logic [1:0] {RR_ARITH, RR_CMP_B, RR_CMP} rret_type;

   function automatic word_type mag(input word_type v);
      return v[WORD_BITS-1] ? word_type'(-v) : v;
   endfunction

endpackage
`default_nettype wire

// File: rtl/rational_arithmetic_unit.sv
// Channel   | ports                    | handshake
// request   | start, busy, req_item    | taken when start is high and busy low
// response  | rsp_valid, rsp_item      | one-cycle strobe, no back-pressure
//
// One item at a time. Every gcd step, reduction and scaling division runs on
// the bit-serial divider, and power runs up to 32 rounds of up to four
// multiplies on the shared multiplier.
// Reset is synchronous, active high; it clears the sequencer and the strobe.
// The result strobe comes the cycle after the last step, when busy drops.
`default_nettype none
module rational_arithmetic_unit import rau_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_valid,
   output rsp_item_type rsp_item
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencer: one state per micro-step, gcd and reduction as subroutines
   rau_controller u_controller (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   // operand registers, 32x32 multiplier, serial divider, result register
   rau_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule
`default_nettype wire

// File: rtl/rau_divider.sv
// Bit-serial restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module rau_divider import rau_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  word_type dividend,
   input  word_type divisor,
   output logic     done,
   output word_type quot,
   output word_type rem
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   word_type            quot_ff, quot_in, rem_ff, rem_in, dsor_ff, dsor_in;
   logic [WORD_BITS:0]  trial, diff;
   logic                fits;

   always_comb begin
      trial   = {rem_ff, quot_ff[WORD_BITS-1]};
      diff    = trial - {1'b0, dsor_ff};
      fits    = (trial >= {1'b0, dsor_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dsor_in = dsor_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quot_in = dividend;
         rem_in  = '0;
         dsor_in = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
         quot_in = {quot_ff[WORD_BITS-2:0], fits};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(WORD_BITS-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsor_ff <= dsor_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule
`default_nettype wire

// File: rtl/rau_datapath.sv
// Datapath: operand registers, shared multiplier, divider and result register.
`default_nettype none
module rau_datapath import rau_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  req_item_type req_item,
   input  dp_cmd_type   cmd,
   output dp_stat_type  stat,
   output logic         rsp_valid,
   output rsp_item_type rsp_item
);

   logic [OP_BITS-1:0]   op_ff, op_in;
   word_type             an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   word_type             iop_ff, iop_in, e_ff, e_in;
   word_type             rn_ff, rn_in, rd_ff, rd_in, l_ff, l_in, x_ff, x_in, y_ff, y_in;
   word_type             ga_ff, ga_in, gb_ff, gb_in, prod_ff, prod_in;
   rsp_item_type         rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   word_type             pair_n, pair_d, div_a, div_b, quot, rem, sq, mul_a, mul_b;
   word_type             qn, qd;
   logic                 div_start, div_done, sq_neg, eq_ab, gt_xy, gt_yx;
   word_type             prod_full;

   rau_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quot     (quot),
      .rem      (rem)
   );

   always_comb begin
      unique case (cmd.pair)
         PAIR_A:  begin pair_n = an_ff; pair_d = ad_ff; end
         PAIR_B:  begin pair_n = bn_ff; pair_d = bd_ff; end
         PAIR_R:  begin pair_n = rn_ff; pair_d = rd_ff; end
         PAIR_D:  begin pair_n = ad_ff; pair_d = bd_ff; end
         default: begin pair_n = an_ff; pair_d = ad_ff; end
      endcase
   end

   // divider operand select
   always_comb begin
      div_start = 1'b1;
      div_a     = ga_ff;
      div_b     = gb_ff;
      case (cmd.op)
         DP_DIV_GCD: ;
         DP_DIV_N:   begin div_a = mag(pair_n); div_b = ga_ff; end
         DP_DIV_D:   begin div_a = mag(pair_d); div_b = ga_ff; end
         DP_DIV_LCM: begin div_a = mag(ad_ff);  div_b = ga_ff; end
         DP_DIV_SX:  begin div_a = mag(l_ff);   div_b = mag(ad_ff); end
         DP_DIV_SY:  begin div_a = mag(l_ff);   div_b = mag(bd_ff); end
         default:    div_start = 1'b0;
      endcase
   end

   // signed quotient of l by a denominator
   assign sq_neg = l_ff[WORD_BITS-1] ^
                   ((cmd.msel == M_SY) ? bd_ff[WORD_BITS-1] : ad_ff[WORD_BITS-1]);
   assign sq = sq_neg ? word_type'(-quot) : quot;
   assign qn = pair_n[WORD_BITS-1] ? word_type'(-quot) : quot;
   assign qd = pair_d[WORD_BITS-1] ? word_type'(-quot) : quot;

   always_comb begin
      unique case (cmd.msel)
         M_AN_BN:  begin mul_a = an_ff; mul_b = bn_ff; end
         M_AD_BD:  begin mul_a = ad_ff; mul_b = bd_ff; end
         M_AN_BD:  begin mul_a = an_ff; mul_b = bd_ff; end
         M_AD_BN:  begin mul_a = ad_ff; mul_b = bn_ff; end
         M_AN_IOP: begin mul_a = an_ff; mul_b = iop_ff; end
         M_LCM:    begin mul_a = quot;  mul_b = mag(bd_ff); end
         M_SX:     begin mul_a = an_ff; mul_b = sq; end
         M_SY:     begin mul_a = bn_ff; mul_b = sq; end
         M_RN_X:   begin mul_a = rn_ff; mul_b = x_ff; end
         M_RD_Y:   begin mul_a = rd_ff; mul_b = y_ff; end
         M_X_X:    begin mul_a = x_ff;  mul_b = x_ff; end
         M_Y_Y:    begin mul_a = y_ff;  mul_b = y_ff; end
         default:  begin mul_a = an_ff; mul_b = bn_ff; end
      endcase
   end

   // products wrap to the word
   assign prod_full = mul_a * mul_b;
   assign prod_in   = cmd.mul_en ? prod_full : prod_ff;

   assign eq_ab = (an_ff == bn_ff) && (ad_ff == bd_ff);
   assign gt_xy = ($signed(x_ff) > $signed(y_ff));
   assign gt_yx = ($signed(y_ff) > $signed(x_ff));

   always_comb begin
      op_in        = op_ff;
      an_in        = an_ff;
      ad_in        = ad_ff;
      bn_in        = bn_ff;
      bd_in        = bd_ff;
      iop_in       = iop_ff;
      e_in         = e_ff;
      rn_in        = rn_ff;
      rd_in        = rd_ff;
      l_in         = l_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      ga_in        = ga_ff;
      gb_in        = gb_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      case (cmd.op)
         DP_LOAD: begin
            op_in  = req_item.req_type;
            an_in  = word_type'(req_item.a_num);
            ad_in  = word_type'(req_item.a_den);
            bn_in  = word_type'(req_item.b_num);
            bd_in  = word_type'(req_item.b_den);
            iop_in = word_type'(req_item.int_operand);
         end
         DP_GCD_INIT: begin
            ga_in = mag(pair_n);
            gb_in = mag(pair_d);
         end
         DP_WB_GCD: begin
            ga_in = gb_ff;
            gb_in = rem;
         end
         DP_WB_N: begin
            case (cmd.pair)
               PAIR_A:  an_in = qn;
               PAIR_B:  bn_in = qn;
               PAIR_R:  rn_in = qn;
               default: ;
            endcase
         end
         DP_WB_D: begin
            case (cmd.pair)
               PAIR_A:  ad_in = qd;
               PAIR_B:  bd_in = qd;
               PAIR_R:  rd_in = qd;
               default: ;
            endcase
         end
         DP_ADD: begin rn_in = x_ff + y_ff; rd_in = l_ff; end
         DP_SUB: begin rn_in = x_ff - y_ff; rd_in = l_ff; end
         DP_NEG: begin rn_in = word_type'(-an_ff); rd_in = ad_ff; end
         DP_RD_AD: rd_in = ad_ff;
         DP_POW_INIT: begin
            // negative exponent: swap, then use its magnitude
            if (iop_ff[WORD_BITS-1]) begin
               x_in = ad_ff;
               y_in = an_ff;
            end else begin
               x_in = an_ff;
               y_in = ad_ff;
            end
            e_in  = mag(iop_ff);
            rn_in = word_type'(1);
            rd_in = word_type'(1);
         end
         DP_E_SHIFT: e_in = e_ff >> 1;
         DP_FIN_OK: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '0;
            case (op_ff) inside
               [OP_ADD:OP_SCALAR]: begin
                  rsp_in.res_num = $signed(rn_ff);
                  rsp_in.res_den = $signed(rd_ff);
               end
               OP_EQ:   rsp_in.cmp_true = eq_ab;
               OP_NE:   rsp_in.cmp_true = !eq_ab;
               OP_GT:   rsp_in.cmp_true = gt_xy;
               OP_GE:   rsp_in.cmp_true = !gt_yx;
               OP_LT:   rsp_in.cmp_true = gt_yx;
               OP_LE:   rsp_in.cmp_true = !gt_xy;
               default: ;
            endcase
         end
         DP_FIN_ERR: begin
            rsp_valid_in  = 1'b1;
            rsp_in        = '0;
            rsp_in.status = 1'b1;
         end
         default: ;
      endcase
      if (cmd.wb_en) begin
         case (cmd.dst)
            DST_RN:  rn_in = prod_ff;
            DST_RD:  rd_in = prod_ff;
            DST_L:   l_in  = prod_ff;
            DST_X:   x_in  = prod_ff;
            DST_Y:   y_in  = prod_ff;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      an_ff   <= an_in;
      ad_ff   <= ad_in;
      bn_ff   <= bn_in;
      bd_ff   <= bd_in;
      iop_ff  <= iop_in;
      e_ff    <= e_in;
      rn_ff   <= rn_in;
      rd_ff   <= rd_in;
      l_ff    <= l_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      ga_ff   <= ga_in;
      gb_ff   <= gb_in;
      prod_ff <= prod_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      stat.op       = op_ff;
      stat.ad_zero  = (ad_ff == '0);
      stat.bd_zero  = (bd_ff == '0);
      stat.ga_zero  = (ga_ff == '0);
      stat.gb_zero  = (gb_ff == '0);
      stat.div_done = div_done;
      stat.e_zero   = (e_ff == '0);
      stat.e_odd    = e_ff[0];
      stat.rd_zero  = (rd_ff == '0);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule
`default_nettype wire

// File: rtl/rau_controller.sv
// Controller: sequences the datapath through each operation.
`default_nettype none
module rau_controller import rau_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  dp_stat_type stat,
   output logic        busy,
   output dp_cmd_type  cmd
);

   state_type state_ff, state_in;
   gret_type  g_ret_ff, g_ret_in;
   rret_type  r_ret_ff, r_ret_in;
   pair_type  pair_ff, pair_in;
   state_type r_target;

   always_comb begin
      unique case (r_ret_ff)
         RR_ARITH: r_target = S_FIN;
         RR_CMP_B: r_target = S_C_B;
         RR_CMP:   r_target = S_C_CMP;
         default:  r_target = S_FIN;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      g_ret_in = g_ret_ff;
      r_ret_in = r_ret_ff;
      pair_in  = pair_ff;
      cmd      = CMD_NOP;
      cmd.pair = pair_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = DP_LOAD;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.op > OP_LE) begin
               cmd.op   = DP_FIN_OK;
               state_in = S_IDLE;
            end else if (stat.ad_zero || (stat.bd_zero && stat.op != OP_POW &&
                                         stat.op != OP_NEG && stat.op != OP_SCALAR)) begin
               cmd.op   = DP_FIN_ERR;
               state_in = S_IDLE;
            end else begin
               case (stat.op) inside
                  OP_ADD, OP_SUB: begin
                     cmd.op   = DP_GCD_INIT;
                     cmd.pair = PAIR_D;
                     g_ret_in = GR_LCM;
                     state_in = S_G_TEST;
                  end
                  OP_MUL, OP_DIV: begin
                     cmd.mul_en = 1'b1;
                     cmd.msel   = (stat.op == OP_MUL) ? M_AN_BN : M_AN_BD;
                     state_in   = S_M2;
                  end
                  OP_POW: begin
                     cmd.op   = DP_POW_INIT;
                     state_in = S_P_TEST;
                  end
                  OP_NEG: begin
                     cmd.op   = DP_NEG;
                     state_in = S_A_END;
                  end
                  OP_SCALAR: begin
                     cmd.mul_en = 1'b1;
                     cmd.msel   = M_AN_IOP;
                     state_in   = S_SC;
                  end
                  default: begin
                     // comparisons: reduce a, then b
                     cmd.op   = DP_GCD_INIT;
                     cmd.pair = PAIR_A;
                     pair_in  = PAIR_A;
                     g_ret_in = GR_RED;
                     r_ret_in = RR_CMP_B;
                     state_in = S_G_TEST;
                  end
               endcase
            end
         end
         // Euclid loop on ga, gb
         S_G_TEST: begin
            if (stat.gb_zero) begin
               state_in = (g_ret_ff == GR_LCM) ? S_L_DIV : S_R_CHK;
            end else begin
               cmd.op   = DP_DIV_GCD;
               state_in = S_G_WAIT;
            end
         end
         S_G_WAIT: begin
            if (stat.div_done) begin
               cmd.op   = DP_WB_GCD;
               state_in = S_G_TEST;
            end
         end
         // reduction of the selected pair by the gcd in ga
         S_R_CHK: begin
            if (stat.ga_zero) begin
               state_in = r_target;
            end else begin
               cmd.op   = DP_DIV_N;
               state_in = S_R_WN;
            end
         end
         S_R_WN: begin
            if (stat.div_done) begin
               cmd.op   = DP_WB_N;
               state_in = S_R_D;
            end
         end
         S_R_D: begin
            cmd.op   = DP_DIV_D;
            state_in = S_R_WD;
         end
         S_R_WD: begin
            if (stat.div_done) begin
               cmd.op   = DP_WB_D;
               state_in = r_target;
            end
         end
         // lcm and scaled numerators
         S_L_DIV: begin
            cmd.op   = DP_DIV_LCM;
            state_in = S_L_WAIT;
         end
         S_L_WAIT: begin
            if (stat.div_done) begin
               cmd.mul_en = 1'b1;
               cmd.msel   = M_LCM;
               state_in   = S_L_WB;
            end
         end
         S_L_WB: begin
            cmd.wb_en = 1'b1;
            cmd.dst   = DST_L;
            state_in  = S_X_DIV;
         end
         S_X_DIV: begin
            cmd.op   = DP_DIV_SX;
            state_in = S_X_WAIT;
         end
         S_X_WAIT: begin
            if (stat.div_done) begin
               cmd.mul_en = 1'b1;
               cmd.msel   = M_SX;
               state_in   = S_X_WB;
            end
         end
         S_X_WB: begin
            cmd.wb_en = 1'b1;
            cmd.dst   = DST_X;
            state_in  = S_Y_DIV;
         end
         S_Y_DIV: begin
            cmd.op   = DP_DIV_SY;
            state_in = S_Y_WAIT;
         end
         S_Y_WAIT: begin
            if (stat.div_done) begin
               cmd.mul_en = 1'b1;
               cmd.msel   = M_SY;
               state_in   = S_Y_WB;
            end
         end
         S_Y_WB: begin
            cmd.wb_en = 1'b1;
            cmd.dst   = DST_Y;
            state_in  = S_SCALED;
         end
         S_SCALED: begin
            if (stat.op == OP_ADD) begin
               cmd.op   = DP_ADD;
               state_in = S_A_END;
            end else if (stat.op == OP_SUB) begin
               cmd.op   = DP_SUB;
               state_in = S_A_END;
            end else begin
               cmd.op   = DP_FIN_OK;
               state_in = S_IDLE;
            end
         end
         // products
         S_M2: begin
            cmd.wb_en  = 1'b1;
            cmd.dst    = DST_RN;
            cmd.mul_en = 1'b1;
            cmd.msel   = (stat.op == OP_MUL) ? M_AD_BD : M_AD_BN;
            state_in   = S_M3;
         end
         S_M3: begin
            cmd.wb_en = 1'b1;
            cmd.dst   = DST_RD;
            state_in  = S_A_END;
         end
         S_SC: begin
            cmd.op    = DP_RD_AD;
            cmd.wb_en = 1'b1;
            cmd.dst   = DST_RN;
            state_in  = S_A_END;
         end
         // square and multiply
         S_P_TEST: begin
            if (stat.e_zero) begin
               state_in = S_A_END;
            end else if (stat.e_odd) begin
               cmd.mul_en = 1'b1;
               cmd.msel   = M_RN_X;
               state_in   = S_P1;
            end else begin
               cmd.mul_en = 1'b1;
               cmd.msel   = M_X_X;
               state_in   = S_P3;
            end
         end
         S_P1: begin
            cmd.wb_en  = 1'b1;
            cmd.dst    = DST_RN;
            cmd.mul_en = 1'b1;
            cmd.msel   = M_RD_Y;
            state_in   = S_P2;
         end
         S_P2: begin
            cmd.wb_en  = 1'b1;
            cmd.dst    = DST_RD;
            cmd.mul_en = 1'b1;
            cmd.msel   = M_X_X;
            state_in   = S_P3;
         end
         S_P3: begin
            cmd.wb_en  = 1'b1;
            cmd.dst    = DST_X;
            cmd.mul_en = 1'b1;
            cmd.msel   = M_Y_Y;
            state_in   = S_P4;
         end
         S_P4: begin
            cmd.wb_en = 1'b1;
            cmd.dst   = DST_Y;
            cmd.op    = DP_E_SHIFT;
            state_in  = S_P_TEST;
         end
         S_A_END: begin
            if (stat.rd_zero) begin
               cmd.op   = DP_FIN_ERR;
               state_in = S_IDLE;
            end else if (stat.op <= OP_POW) begin
               cmd.op   = DP_GCD_INIT;
               cmd.pair = PAIR_R;
               pair_in  = PAIR_R;
               g_ret_in = GR_RED;
               r_ret_in = RR_ARITH;
               state_in = S_G_TEST;
            end else begin
               cmd.op   = DP_FIN_OK;
               state_in = S_IDLE;
            end
         end
         S_FIN: begin
            cmd.op   = DP_FIN_OK;
            state_in = S_IDLE;
         end
         S_C_B: begin
            cmd.op   = DP_GCD_INIT;
            cmd.pair = PAIR_B;
            pair_in  = PAIR_B;
            g_ret_in = GR_RED;
            r_ret_in = RR_CMP;
            state_in = S_G_TEST;
         end
         S_C_CMP: begin
            if (stat.op == OP_EQ || stat.op == OP_NE) begin
               cmd.op   = DP_FIN_OK;
               state_in = S_IDLE;
            end else begin
               cmd.op   = DP_GCD_INIT;
               cmd.pair = PAIR_D;
               g_ret_in = GR_LCM;
               state_in = S_G_TEST;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         g_ret_ff <= GR_LCM;
         r_ret_ff <= RR_ARITH;
         pair_ff  <= PAIR_A;
      end else begin
         state_ff <= state_in;
         g_ret_ff <= g_ret_in;
         r_ret_ff <= r_ret_in;
         pair_ff  <= pair_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule
`default_nettype wire

// File: rtl/rau_checker.sv
// Port-level checks for the rational arithmetic unit, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module rau_checker import rau_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input logic         rsp_valid,
   input rsp_item_type rsp_item
);

   `RAU_ASSERT_NXT(a_accept_busy, start && !busy, busy, "item taken but unit not busy")
   `RAU_ASSERT_NXT(a_single_strobe, rsp_valid, !rsp_valid, "result strobe longer than a cycle")
   `RAU_ASSERT_IMP(a_done_idle, rsp_valid, !busy, "result shown while still busy")
   `RAU_ASSERT_IMP(a_err_clean, rsp_valid && rsp_item.status,
      rsp_item.res_num == 0 && rsp_item.res_den == 0 && !rsp_item.cmp_true,
      "error item carries data")
   `RAU_ASSERT_RST(a_reset_idle, !busy && !rsp_valid, "not idle after reset")

endmodule

bind rational_arithmetic_unit rau_checker u_checker (.*);
`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for the rational arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none
module tb;
   import rau_pkg::*;

   localparam int RANDOM_ITEMS = 1400;
   // Idle cycles allowed with no item taken and no result seen, sized for the
   // slowest items (many gcd steps, full-range power).
   localparam int STALL_LIMIT  = 200000;
   localparam int TAIL_CYCLES  = 100;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_item;
   logic         rsp_valid;
   rsp_item_type rsp_item;

   rational_arithmetic_unit uut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Outputs are sampled mid-cycle, so each edge sees settled values.
   logic         busy_s;
   logic         rsp_valid_s;
   rsp_item_type rsp_item_s;
   always @(negedge clock) begin
      busy_s      <= busy;
      rsp_valid_s <= rsp_valid;
      rsp_item_s  <= rsp_item;
   end

   rsp_item_type pending_results[$];
   int           mismatches;
   int           items_sent;
   int           results_seen;
   int           stall_cycles;

   // ---------------------------------------------------------------------
   // Fraction arithmetic, all words wrapped to 32 bits
   // ---------------------------------------------------------------------
   function automatic word_type magnitude(input word_type v);
      return v[WORD_BITS-1] ? word_type'(-v) : v;
   endfunction

   function automatic word_type gcd_of(input word_type x, input word_type y);
      word_type t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic word_type div_by_magnitude(input word_type x, input word_type m);
      word_type q;
      q = magnitude(x) / m;
      return x[WORD_BITS-1] ? word_type'(-q) : q;
   endfunction

   function automatic word_type signed_quot(input word_type x, input word_type y);
      word_type q;
      q = magnitude(x) / magnitude(y);
      return (x[WORD_BITS-1] ^ y[WORD_BITS-1]) ? word_type'(-q) : q;
   endfunction

   function automatic word_type lcm_of(input word_type x, input word_type y);
      word_type mx, my;
      mx = magnitude(x);
      my = magnitude(y);
      if (mx == 0 || my == 0) return '0;
      return word_type'((mx / gcd_of(mx, my)) * my);
   endfunction

   // Divides both by the gcd of their magnitudes; signs are kept as they are.
   function automatic void reduce_fraction(inout word_type n, inout word_type d);
      word_type g;
      g = gcd_of(magnitude(n), magnitude(d));
      if (g == 0) return;
      n = div_by_magnitude(n, g);
      d = div_by_magnitude(d, g);
   endfunction

   function automatic word_type power_of(input word_type b, input word_type e);
      word_type r;
      r = 1;
      while (e != 0) begin
         if (e[0]) r = word_type'(r * b);
         b = word_type'(b * b);
         e = e >> 1;
      end
      return r;
   endfunction

   function automatic rsp_item_type fraction_result(input req_item_type q);
      rsp_item_type r;
      word_type     an, ad, bn, bd, rn, rd, l, x, y, e;
      logic         reads_b;
      r       = '0;
      an      = q.a_num;
      ad      = q.a_den;
      bn      = q.b_num;
      bd      = q.b_den;
      rn      = '0;
      rd      = '0;
      reads_b = !(q.req_type inside {OP_POW, OP_NEG, OP_SCALAR});
      if (q.req_type > OP_LE) return r;
      if (ad == 0 || (bd == 0 && reads_b)) begin
         r.status = 1'b1;
         return r;
      end
      if (q.req_type <= OP_SCALAR) begin
         case (q.req_type)
            OP_ADD, OP_SUB: begin
               l  = lcm_of(ad, bd);
               x  = word_type'(an * signed_quot(l, ad));
               y  = word_type'(bn * signed_quot(l, bd));
               rn = (q.req_type == OP_ADD) ? word_type'(x + y) : word_type'(x - y);
               rd = l;
            end
            OP_MUL: begin
               rn = word_type'(an * bn);
               rd = word_type'(ad * bd);
            end
            OP_DIV: begin
               rn = word_type'(an * bd);
               rd = word_type'(ad * bn);
            end
            OP_POW: begin
               // negative exponent: reciprocal first, then the magnitude
               if (q.int_operand[WORD_BITS-1]) begin
                  e  = word_type'(-q.int_operand);
                  rn = power_of(ad, e);
                  rd = power_of(an, e);
               end else begin
                  e  = q.int_operand;
                  rn = power_of(an, e);
                  rd = power_of(ad, e);
               end
            end
            OP_NEG: begin
               rn = word_type'(-an);
               rd = ad;
            end
            default: begin
               rn = word_type'(an * q.int_operand);
               rd = ad;
            end
         endcase
         if (rd == 0) begin
            r.status = 1'b1;
            return r;
         end
         if (q.req_type <= OP_POW) reduce_fraction(rn, rd);
         r.res_num = rn;
         r.res_den = rd;
      end else begin
         reduce_fraction(an, ad);
         reduce_fraction(bn, bd);
         if (q.req_type == OP_EQ || q.req_type == OP_NE) begin
            r.cmp_true = ((an == bn) && (ad == bd)) ^ (q.req_type == OP_NE);
         end else begin
            l = lcm_of(ad, bd);
            x = word_type'(an * signed_quot(l, ad));
            y = word_type'(bn * signed_quot(l, bd));
            case (q.req_type)
               OP_GT:   r.cmp_true = $signed(x) > $signed(y);
               OP_GE:   r.cmp_true = !($signed(y) > $signed(x));
               OP_LT:   r.cmp_true = $signed(y) > $signed(x);
               default: r.cmp_true = !($signed(x) > $signed(y));
            endcase
         end
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid_s) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch("result with no item outstanding");
         end else begin
            want = pending_results.pop_front();
            if (rsp_item_s.res_num !== want.res_num)
               report_mismatch($sformatf("res_num %h, want %h",
                                         rsp_item_s.res_num, want.res_num));
            if (rsp_item_s.res_den !== want.res_den)
               report_mismatch($sformatf("res_den %h, want %h",
                                         rsp_item_s.res_den, want.res_den));
            if (rsp_item_s.cmp_true !== want.cmp_true)
               report_mismatch($sformatf("cmp_true %b, want %b",
                                         rsp_item_s.cmp_true, want.cmp_true));
            if (rsp_item_s.status !== want.status)
               report_mismatch($sformatf("status %b, want %b",
                                         rsp_item_s.status, want.status));
         end
      end
   end

   // Watchdog: a long run of cycles with nothing taken and nothing returned.
   always @(posedge clock) begin
      if (reset || (start && !busy_s) || rsp_valid_s) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog expired with %0d results outstanding",
                     pending_results.size());
            $display("tb NOT OK");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   typedef struct {
      req_item_type item;
      logic         typed;
      rsp_item_type want;
   } stim_row_type;

   stim_row_type directed_rows[$];

   function automatic void add_row(input logic [OP_BITS-1:0] op, input word_type an,
                                   input word_type ad, input word_type bn,
                                   input word_type bd, input word_type iop,
                                   input logic typed = 1'b0,
                                   input rsp_item_type want = '0);
      stim_row_type s;
      s.item  = '{req_type: op, a_num: an, a_den: ad, b_num: bn, b_den: bd,
                  int_operand: iop};
      s.typed = typed;
      s.want  = want;
      directed_rows.push_back(s);
   endfunction

   // Holds start high until the item is taken. A zero gap keeps start up
   // from the previous item, so it is never lowered and raised in one step.
   task automatic send_item(input req_item_type q, input logic typed,
                            input rsp_item_type want);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= q;
      do @(posedge clock); while (busy_s);
      pending_results.push_back(typed ? want : fraction_result(q));
      items_sent++;
   endtask

   function automatic word_type pick_word(input logic nonzero);
      word_type w;
      case ($urandom_range(0, 9))
         0, 1:    w = $urandom();
         2:       w = $urandom_range(0, 3) == 0 ? 32'h8000_0000 :
                      $urandom_range(0, 1) ? 32'h7fff_ffff : 32'hffff_ffff;
         3:       w = word_type'($signed($urandom_range(0, 2000)) - 1000);
         default: w = word_type'($signed($urandom_range(0, 40)) - 20);
      endcase
      if (nonzero && w == 0 && $urandom_range(0, 7) != 0) w = 1;
      return w;
   endfunction

   function automatic req_item_type random_item();
      req_item_type q;
      q.req_type = ($urandom_range(0, 40) == 0) ? OP_BITS'($urandom_range(13, 15))
                                                : OP_BITS'($urandom_range(0, 12));
      q.a_num    = pick_word(1'b0);
      q.a_den    = pick_word(1'b1);
      q.b_num    = pick_word(1'b0);
      q.b_den    = pick_word(1'b1);
      if (q.req_type == OP_POW && $urandom_range(0, 5) != 0)
         q.int_operand = word_type'($signed($urandom_range(0, 16)) - 8);
      else
         q.int_operand = pick_word(1'b0);
      return q;
   endfunction

   initial begin
      rsp_item_type ok_zero, zero_den, unit_one, neg_half, cmp_yes;
      mismatches   = 0;
      items_sent   = 0;
      results_seen = 0;
      start        = 1'b0;
      req_item     = '0;
      reset        = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      ok_zero  = '0;
      zero_den = '{res_num: '0, res_den: '0, cmp_true: 1'b0, status: 1'b1};
      unit_one = '{res_num: 32'sd1, res_den: 32'sd1, cmp_true: 1'b0, status: 1'b0};
      neg_half = '{res_num: -32'sd2, res_den: 32'sd4, cmp_true: 1'b0, status: 1'b0};
      cmp_yes  = '{res_num: '0, res_den: '0, cmp_true: 1'b1, status: 1'b0};

      add_row(OP_ADD, 1, 2, 1, 3, 0);
      add_row(OP_SUB, 1, 2, 1, 3, 0);
      add_row(OP_ADD, 32'h7fff_ffff, 1, 1, 1, 0);
      add_row(OP_SUB, 32'h8000_0000, 32'hffff_ffff, 1, 32'h8000_0000, 0);
      add_row(OP_MUL, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 3, 0);
      add_row(OP_MUL, 0, 5, 7, 9, 0);
      add_row(OP_DIV, 3, 4, 0, 5, 0);                   // zero result denominator
      add_row(OP_DIV, -6, 8, 9, -12, 0);
      add_row(OP_POW, 3, 5, 1, 1, 0, 1'b1, unit_one);  // zero exponent
      add_row(OP_POW, 2, 3, 1, 1, -3);                  // reciprocal first
      add_row(OP_POW, 32'hffff_ffff, 32'h7fff_ffff, 1, 1, 32'h8000_0000);
      add_row(OP_POW, 0, 7, 1, 1, -2);                  // reciprocal of zero
      add_row(OP_NEG, 2, 4, 0, 0, 0, 1'b1, neg_half);  // b ignored, not reduced
      add_row(OP_NEG, 32'h8000_0000, 1, 1, 1, 0);
      add_row(OP_SCALAR, 3, 6, 0, 0, 32'h7fff_ffff);
      add_row(OP_ADD, 1, 0, 1, 1, 0, 1'b1, zero_den);  // a denominator zero
      add_row(OP_GT, 1, 2, 1, 0, 0, 1'b1, zero_den);   // b denominator zero
      add_row(OP_EQ, 1, 2, 2, 4, 0, 1'b1, cmp_yes);
      add_row(OP_NE, 1, 2, 2, 4, 0, 1'b1, ok_zero);
      add_row(OP_NE, 1, 2, -1, -2, 0);                  // signs not normalised
      add_row(OP_GT, 1, 3, 1, 2, 0);
      add_row(OP_GE, 2, 4, 1, 2, 0);
      add_row(OP_LT, 32'h8000_0000, 1, 32'h7fff_ffff, 1, 0);
      add_row(OP_LE, -1, 3, 1, -3, 0);
      add_row(4'(OP_LE + 1), 1, 1, 1, 1, 1, 1'b1, ok_zero);
      add_row(4'hf, 32'hffff_ffff, 0, 32'hffff_ffff, 0, 32'hffff_ffff, 1'b1, ok_zero);

      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // once mid-run, drain the block completely before carrying on
         if (n == RANDOM_ITEMS / 2) begin
            start <= 1'b0;
            while (pending_results.size() != 0) @(posedge clock);
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         send_item(random_item(), 1'b0, '0);
      end
      @(posedge clock);
      start <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d items sent (%0d directed), %0d results checked, all operations",
               items_sent, directed_rows.size(), results_seen);
      $display("and error cases covered, %0d mismatches", mismatches);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
`default_nettype wire
